// File: hdl/sha256_pkg.sv
// SHA-256 hasher package: round constants, initial hash values, state enum.
// Used by sha256_round and the top level; depends on nothing.
`default_nettype none
package sha256_pkg;

	localparam int unsigned RoundCount = 64;

	localparam logic FuncAbsorb = 1'b0;
	localparam logic FuncFinish = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} rnd_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// File: hdl/sha256_byte_stream_hasher_core.sv
// SHA-256 byte-stream hasher top level: buffer, sequencer, digest output.
// Instantiates sha256_round; uses sha256_pkg.
// Absorb accepts one byte; when it fills a block, accept is followed by load, the rounds and fold.
// Finish pads one byte per cycle, runs one or two compressions, then
// presents 8 digest words, one per accepted output cycle.
// Reset restores initial hash words, zero fill count and zero bit count.
`default_nettype none
module sha256_byte_stream_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha256_pkg::state_t state_q, state_d;
	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] hash_q [8];
	logic [6:0]  cnt_q;
	logic        fin_q;
	// fin_q: long tail, a second block still needs the length
	logic        padding_q;
	logic [255:0] hash_flat, vars;
	logic [31:0] sched_word;
	sha256_pkg::rnd_ctl_t ctl;
	logic        acc, wr_en, to_emit;
	logic [7:0]  wr_byte;
	logic [5:0]  wr_addr;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != sha256_pkg::ST_IDLE);

	always_comb begin
		for (int i = 0; i < 8; i++) hash_flat[255 - 32*i -: 32] = hash_q[i];
		sched_word = buf_q[cnt_q[3:0]];
	end

	sha256_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .hash_in(hash_flat),
		.sched_in(sched_word), .round_idx(cnt_q[5:0]), .vars(vars)
	);

	// padding byte at fill_q: 0x80 first, zeros, then length at 56..63 of last block
	always_comb begin
		state_d = state_q;
		ctl = '0;
		wr_en = 1'b0;
		wr_byte = 8'h00;
		wr_addr = fill_q;
		to_emit = 1'b0;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (acc) begin
					wr_en = 1'b1;
					wr_byte = (func == sha256_pkg::FuncFinish) ? 8'h80 : data_byte;
					if (func == sha256_pkg::FuncFinish)
						state_d = (fill_q == 6'd63) ? sha256_pkg::ST_LOAD
							: sha256_pkg::ST_PAD;
					else if (fill_q == 6'd63) state_d = sha256_pkg::ST_LOAD;
				end
			end
			sha256_pkg::ST_PAD: begin
				wr_en = 1'b1;
				if (fill_q >= 6'd56 && !fin_q)
					wr_byte = bits_q[63 - 8*(fill_q - 6'd56) -: 8];
				if (fill_q == 6'd63) state_d = sha256_pkg::ST_LOAD;
			end
			sha256_pkg::ST_LOAD: begin
				ctl.start = 1'b1;
				state_d = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_ROUND: begin
				ctl.step = 1'b1;
				if (cnt_q == 7'(sha256_pkg::RoundCount - 1)) state_d = sha256_pkg::ST_FOLD;
			end
			sha256_pkg::ST_FOLD: begin
				to_emit = 1'b1;
				priority if (fin_q) state_d = sha256_pkg::ST_PAD;
				else if (padding_q) state_d = sha256_pkg::ST_EMIT;
				else state_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_EMIT: begin
				if (!out_stall && cnt_q[2:0] == 3'd7) state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha256_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[wr_addr[5:2]][8*(3 - wr_addr[1:0]) +: 8] <= wr_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			padding_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_hash(3'(i));
		end else begin
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (state_q == sha256_pkg::ST_IDLE && acc) begin
				if (func == sha256_pkg::FuncAbsorb) bits_q <= bits_q + 64'd8;
				padding_q <= (func == sha256_pkg::FuncFinish);
				fin_q <= (func == sha256_pkg::FuncFinish) && (fill_q > 6'd55);
			end
			if (state_q == sha256_pkg::ST_LOAD) cnt_q <= '0;
			else if (state_q == sha256_pkg::ST_ROUND) cnt_q <= cnt_q + 7'd1;
			else if (state_q == sha256_pkg::ST_FOLD) cnt_q <= '0;
			else if (state_q == sha256_pkg::ST_EMIT && !out_stall) cnt_q <= cnt_q + 7'd1;
			if (to_emit) begin
				fin_q <= 1'b0;
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars[255 - 32*i -: 32];
			end
			if (state_q == sha256_pkg::ST_EMIT && !out_stall && cnt_q[2:0] == 3'd7) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_hash(3'(i));
				bits_q <= '0;
				padding_q <= 1'b0;
			end
		end
	end

	assign out_valid = (state_q == sha256_pkg::ST_EMIT);
	assign digest_word = hash_q[cnt_q[2:0]];
	assign word_index = cnt_q[2:0];
	assign last_word = (cnt_q[2:0] == 3'd7);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_ROUND) |-> in_stall)
		else $error("input taken during rounds");
	a_emit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 6'd0))
		else $error("buffer not empty at digest");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_FOLD) |-> $past(cnt_q) == 7'd63)
		else $error("fold before last round");

endmodule
`default_nettype wire

// File: hdl/sha256_round.sv
// SHA-256 round unit: one compression round and one schedule word per step.
// Holds the working variables and a 16-word schedule window; uses sha256_pkg.
`default_nettype none
module sha256_round (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::rnd_ctl_t ctl,
	input  wire logic [255:0]        hash_in,
	input  wire logic [31:0]         sched_in,
	input  wire logic [5:0]          round_idx,
	output logic [255:0]             vars
);

	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] w_cur, w_new, t1, t2, big0, big1, ch, maj, s0, s1;

	always_comb begin
		s0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = (round_idx < 6'd16) ? sched_in : w_new;
		big1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha256_pkg::round_k(round_idx) + w_cur;
		big0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
	end

	// window: w_q[0] is oldest of the last 16 words; w_new is the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
		end else if (ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_in[255 - 32*i -: 32];
		end else if (ctl.step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// shift so that after step i, w_q[15] holds w[i]
	logic [31:0] nxt;
	always_comb begin
		nxt = w_new;
		if (round_idx < 6'd16) nxt = sched_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else if (ctl.step) begin
			if (round_idx < 6'd16) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= nxt;
			end else begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) vars[255 - 32*i -: 32] = v_q[i];
	end

endmodule
`default_nettype wire

// File: test/sha256_byte_stream_hasher_core_tb.sv
// Testbench for sha256_byte_stream_hasher_core: byte stream in, digest words out.
// Predicts each digest with a behavioral SHA-256 and checks every output word.
// Depends on the core RTL and sha256_pkg.
`default_nettype none
module sha256_byte_stream_hasher_core_tb;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       hold;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic func = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid, last_word;
	logic [31:0] digest_word;
	logic [2:0] word_index;

	byte_item_t pending_bytes[$];
	digest_out_t expected_digest[$];
	int errors = 0;
	int cycles = 0;
	int in_wait = 0;
	int out_wait = 0;
	bit feeding_done = 0;

	logic [31:0] hash_state[8];
	logic [7:0] msg_block[64];
	int fill_bytes = 0;
	logic [63:0] bit_total = 64'd0;

	sha256_byte_stream_hasher_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
			hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ sha256_pkg::round_k(i[5:0]) + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic clear_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = sha256_pkg::init_hash(i[2:0]);
		fill_bytes = 0;
		bit_total = 64'd0;
	endtask

	task automatic append_byte(input logic [7:0] b);
		msg_block[fill_bytes] = b;
		fill_bytes++;
		if (fill_bytes == 64) begin
			compress_block();
			fill_bytes = 0;
		end
	endtask

	task automatic predict_digest(input byte_item_t it);
		logic [63:0] len;
		if (it.func == sha256_pkg::FuncAbsorb) begin
			bit_total += 64'd8;
			append_byte(it.data_byte);
		end else begin
			len = bit_total;
			append_byte(8'h80);
			while (fill_bytes != 56)
				append_byte(8'h00);
			for (int k = 7; k >= 0; k--)
				append_byte(len[8*k +: 8]);
			for (int k = 0; k < 8; k++)
				expected_digest.push_back({hash_state[k], k[2:0], k == 7});
			clear_hash();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic queue_message(input int len, input logic [7:0] fixed, input bit use_fixed);
		for (int i = 0; i < len; i++)
			pending_bytes.push_back({sha256_pkg::FuncAbsorb,
				use_fixed ? fixed : 8'($urandom_range(0, 255)), 1'b0});
		pending_bytes.push_back({sha256_pkg::FuncFinish, 8'($urandom_range(0, 255)), 1'b0});
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_digest({func, data_byte, 1'b0});
				in_wait = $urandom_range(0, 5);
			end
			if (in_valid && in_stall) begin
			end else if (pending_bytes.size() == 0) begin
				feeding_done = 1;
				in_valid <= 1'b0;
			end else if (pending_bytes[0].hold && expected_digest.size() != 0) begin
				in_valid <= 1'b0;
			end else if (in_wait > 0) begin
				in_wait--;
				in_valid <= 1'b0;
			end else begin
				func <= pending_bytes[0].func;
				data_byte <= pending_bytes[0].data_byte;
				in_valid <= 1'b1;
				void'(pending_bytes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_digest.size() == 0) begin
					report_mismatch("unexpected word", digest_word, 32'd0);
				end else begin
					if (digest_word !== expected_digest[0].digest_word)
						report_mismatch("digest_word", digest_word, expected_digest[0].digest_word);
					if (word_index !== expected_digest[0].word_index)
						report_mismatch("word_index", 32'(word_index),
							32'(expected_digest[0].word_index));
					if (last_word !== expected_digest[0].last_word)
						report_mismatch("last_word", 32'(last_word),
							32'(expected_digest[0].last_word));
					void'(expected_digest.pop_front());
				end
				out_wait = $urandom_range(0, 5);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int len;
		clear_hash();
		queue_message(0, 8'h00, 1);
		queue_message(3, 8'hff, 1);
		queue_message(1, 8'h00, 1);
		queue_message(2, 8'hff, 1);
		pending_bytes.push_back({sha256_pkg::FuncFinish, 8'h00, 1'b1});
		queue_message(0, 8'hff, 1);
		pending_bytes[pending_bytes.size() - 1].data_byte = 8'hff;
		queue_message(4, 8'h55, 1);
		queue_message(1, 8'haa, 1);
		while (pending_bytes.size() < 350) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(55, 57);
				1: len = $urandom_range(63, 65);
				2: len = $urandom_range(119, 128);
				default: len = $urandom_range(0, 20);
			endcase
			if (pending_bytes.size() + len + 1 > 350)
				len = 349 - pending_bytes.size();
			queue_message(len, 8'h00, 0);
			if ($urandom_range(0, 9) == 0)
				pending_bytes[$urandom_range(0, pending_bytes.size() - 1)].hold = 1'b1;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (feeding_done && !in_valid && expected_digest.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_digest.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
